FILE: hdl/tui_pkg.sv
// constants, phase type and digit decode for the text to unsigned integer parser
package tui_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int BASE_BITS      = 6;
    localparam int CHAR_BITS      = 8;

    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] NO_DIGIT = 8'hFF;

    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_FROZEN = 5'b10000
    } t_phase;

    // digit value 0..35, or NO_DIGIT for any other byte
    function automatic logic [CHAR_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + 8'd10;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

endpackage

FILE: hdl/text_to_unsigned_integer_top.sv
// streaming text to unsigned integer parser, one byte per transfer
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_ready      | i_char_in[7:0]
//  result  | out       | o_out_valid / i_out_ready    | o_value, o_consumed
//  config  | in        | i_cfg_we (no wait)           | i_cfg_wdata[5:0]
//
//  one byte per cycle sustained while no zero byte waits: a byte is registered in
//  the input register, then the parse state and, for a zero byte, the result
//  register are updated from it (multiply by the radix plus add on the
//  accumulator in that one step). a result is valid once its zero byte is processed.
//  reset clears the parse state, the radix register and both valid flags.
//  a zero byte waits in the input register while the result register is full
//  and not taken; other bytes never wait.
module text_to_unsigned_integer_top
    import tui_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BASE_BITS-1:0]  i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_BITS-1:0]  i_char_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [COUNT_BITS-1:0] o_consumed
);

    logic [BASE_BITS-1:0]  r_cfg_base;
    logic                  r_in_valid;
    logic [CHAR_BITS-1:0]  r_char;
    t_phase                r_phase, n_phase;
    logic [BASE_BITS-1:0]  r_base, n_base;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_consumed;

    logic                  out_free, is_nul, advance, process, process_nul;
    logic                  at_signed, at_zero, at_digits, bump;
    logic [CHAR_BITS-1:0]  dig;

    assign out_free    = !r_out_valid || i_out_ready;
    assign is_nul      = (r_char == CH_NUL);
    assign advance     = !is_nul || out_free;
    assign process     = r_in_valid && advance;
    assign process_nul = process && is_nul;
    assign o_in_ready  = !r_in_valid || advance;
    assign dig         = digit_of(r_char);

    always_comb begin
        n_phase   = r_phase;
        n_base    = r_base;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_count   = r_count;
        at_signed = 1'b0;
        at_zero   = 1'b0;
        at_digits = 1'b0;
        bump      = 1'b0;

        unique case (r_phase)
            PH_SPACE: begin
                if (is_space(r_char)) begin
                    bump = 1'b1;
                end else if (r_char == CH_PLUS || r_char == CH_MINUS) begin
                    n_neg   = (r_char == CH_MINUS);
                    bump    = 1'b1;
                    n_phase = PH_SIGNED;
                end else begin
                    at_signed = 1'b1;
                end
            end
            PH_SIGNED: at_signed = 1'b1;
            PH_ZERO:   at_zero   = 1'b1;
            PH_DIGITS: at_digits = 1'b1;
            PH_FROZEN: ;
            default:   ;
        endcase

        // radix is taken from the register at the first byte after any leading spaces and sign
        if (at_signed) begin
            if ((r_cfg_base == BASE_AUTO || r_cfg_base == BASE_HEX) && r_char == CH_0) begin
                n_base  = (r_cfg_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                bump    = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                n_base    = (r_cfg_base == BASE_AUTO) ? BASE_DEC : r_cfg_base;
                at_digits = 1'b1;
            end
        end

        if (at_zero) begin
            if (r_char == CH_LX || r_char == CH_UX) begin
                n_base  = BASE_HEX;
                bump    = 1'b1;
                n_phase = PH_DIGITS;
            end else begin
                at_digits = 1'b1;
            end
        end

        if (at_digits) begin
            if (dig < {{(CHAR_BITS-BASE_BITS){1'b0}}, n_base}) begin
                n_acc   = r_acc * {{(VALUE_BITS-BASE_BITS){1'b0}}, n_base}
                        + {{(VALUE_BITS-CHAR_BITS){1'b0}}, dig};
                bump    = 1'b1;
                n_phase = PH_DIGITS;
            end else begin
                n_phase = PH_FROZEN;
            end
        end

        if (bump && r_count != {COUNT_BITS{1'b1}}) begin
            n_count = r_count + 1'b1;
        end

        // end of string starts the next parse from scratch
        if (is_nul) begin
            n_phase = PH_SPACE;
            n_base  = '0;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_SPACE;
            r_base      <= '0;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_base <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (process) begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_count <= n_count;
            end
            if (process_nul) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
        end
        if (process_nul) begin
            r_value    <= r_neg ? ('0 - r_acc) : r_acc;
            r_consumed <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_consumed  = r_consumed;

    // the input stage only stalls on a zero byte facing a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && is_nul && r_out_valid && !i_out_ready)
        else $error("input stalled without a pending result");

    // end of string always produces a result and restarts the parse
    a_nul_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process_nul |=> r_out_valid && r_phase == PH_SPACE && r_count == '0 && r_acc == '0)
        else $error("zero byte did not produce a result and clear the parse");

    // a frozen parse ignores every further byte but the zero byte
    a_frozen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && !is_nul && r_phase == PH_FROZEN |=>
            $stable(r_acc) && $stable(r_count) && r_phase == PH_FROZEN)
        else $error("frozen parse changed");

    // byte count only grows within a string
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && !is_nul |=> r_count >= $past(r_count))
        else $error("byte count went down within a string");

endmodule
